FILE: rtl/order_entry_framer_pending_table_assert.svh
// Assertion macros for the order entry framer.
// Used by modules that check their own control logic; needs no package.
`ifndef ORDER_ENTRY_FRAMER_PENDING_TABLE_ASSERT_SVH
`define ORDER_ENTRY_FRAMER_PENDING_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OEFT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OEFT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/oeft_pkg.sv
// Shared types, codes and sizes of the order entry framer.
// Depends on nothing; imported by every module of the block.
package oeft_pkg;

    // Pending table size; must be a power of two.
    localparam int PENDING_SLOTS = 1024;
    localparam int SLOT_AW       = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
    localparam int LIVE_W        = $clog2(PENDING_SLOTS + 1);

    // Frame layout.
    localparam int HEADER_BYTES = 3;
    localparam int BODY_BYTES   = 16;
    localparam int FRAME_BYTES  = HEADER_BYTES + BODY_BYTES;
    localparam int BYTE_CW      = $clog2(FRAME_BYTES);
    localparam logic [15:0] FRAME_LEN = 16'(BODY_BYTES + 1);

    localparam logic [7:0] CHAR_U = 8'h55;
    localparam logic [7:0] CHAR_O = 8'h4F;
    localparam logic [7:0] CHAR_B = 8'h42;
    localparam logic [7:0] CHAR_S = 8'h53;

    // Queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Reference counter value after reset.
    localparam logic [31:0] FIRST_REF_RESET = 32'd1;

    typedef logic [SLOT_AW-1:0] slot_idx_t;
    typedef logic [BYTE_CW-1:0] byte_idx_t;
    typedef logic [2:0]         status_t;
    typedef logic [1:0]         kind_t;

    // Input operation and side codes.
    localparam logic OP_ENTER   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;
    localparam logic [1:0] SIDE_BUY  = 2'd0;
    localparam logic [1:0] SIDE_SELL = 2'd1;

    // Command kinds after classification.
    localparam kind_t KIND_ENTER   = 2'd0;
    localparam kind_t KIND_RELEASE = 2'd1;
    localparam kind_t KIND_BAD     = 2'd2;

    // Result status codes.
    localparam status_t STAT_FRAME     = 3'd0;
    localparam status_t STAT_BAD_SIDE  = 3'd1;
    localparam status_t STAT_FULL      = 3'd2;
    localparam status_t STAT_BUSY      = 3'd3;
    localparam status_t STAT_RELEASED  = 3'd4;
    localparam status_t STAT_NOT_FOUND = 3'd5;

    // One classified command as it travels through the queue.
    typedef struct packed {
        kind_t       kind;
        logic [31:0] ref_num;
        logic        sell;
        logic [15:0] locate;
        logic [31:0] shares;
        logic [31:0] price;
    } cmd_t;

    // One pending table entry.
    typedef struct packed {
        logic        occupied;
        logic [31:0] ref_num;
    } slot_entry_t;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Direct-mapped slot of a reference: its low bits.
    function automatic slot_idx_t slot_index(input logic [31:0] ref_num);
        slot_idx_t idx;
        idx = (PENDING_SLOTS == 1) ? '0 : ref_num[SLOT_AW-1:0];
        return idx;
    endfunction

endpackage

FILE: rtl/order_entry_framer_pending_table.sv
// Top level of the order entry framer with its direct-mapped pending table.
// Depends on oeft_pkg, oeft_front, oeft_queue and oeft_back.
//
//   Channel  Direction  Handshake            Payload
//   in       input      in_valid / in_stall  operation, order_side, locate_code,
//                                            share_count, order_price, release_ref
//   out      output     out_valid/out_stall  frame_byte, last, status, order_ref
//   cfg      input      cfg_valid/cfg_ready  first_order_ref
//
// An accepted order goes through one pending table read in the back part,
// then 19 byte transfers. Rejects and releases give one result transfer.
// After reset the back part clears the table one slot a cycle, with in_stall
// high; configuration transfers are taken throughout.
// The two-entry queue lets the front accept items while the output is stalled.
module order_entry_framer_pending_table
    import oeft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [1:0]  order_side,
    input  logic [15:0] locate_code,
    input  logic [31:0] share_count,
    input  logic [31:0] order_price,
    input  logic [31:0] release_ref,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  frame_byte,
    output logic        last,
    output logic [2:0]  status,
    output logic [31:0] order_ref,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] first_order_ref
);

    queue_status_t q_stat;
    logic          clear_busy;
    logic          push;
    cmd_t          push_cmd;
    logic          pop;
    cmd_t          q_head;

    // Front: accept and classify.
    oeft_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .order_side      (order_side),
        .locate_code     (locate_code),
        .share_count     (share_count),
        .order_price     (order_price),
        .release_ref     (release_ref),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .first_order_ref (first_order_ref),
        .q_stat          (q_stat),
        .clear_busy      (clear_busy),
        .push            (push),
        .push_cmd        (push_cmd)
    );

    // Command queue between the two parts.
    oeft_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (q_head),
        .q_stat   (q_stat)
    );

    // Back: table work and result output.
    oeft_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_stat     (q_stat),
        .pop        (pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .last       (last),
        .status     (status),
        .order_ref  (order_ref)
    );

endmodule

FILE: rtl/oeft_front.sv
// Front part: accepts input items, classifies them and assigns references.
// Depends on oeft_pkg; feeds oeft_queue.
module oeft_front
    import oeft_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          operation,
    input  logic [1:0]    order_side,
    input  logic [15:0]   locate_code,
    input  logic [31:0]   share_count,
    input  logic [31:0]   order_price,
    input  logic [31:0]   release_ref,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [31:0]   first_order_ref,
    input  queue_status_t q_stat,
    input  logic          clear_busy,
    output logic          push,
    output cmd_t          push_cmd
);

    logic [31:0] next_ref_reg;
    logic [31:0] next_ref_next;
    logic        in_xfer;
    logic        takes_ref;

    // Items wait while the queue is full or the table is being cleared.
    assign in_stall  = q_stat.full | clear_busy;
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid & ~in_stall;
    assign push      = in_xfer;

    // Classify the item and build the command for the back part.
    always_comb
    begin
        push_cmd         = '0;
        push_cmd.locate  = locate_code;
        push_cmd.shares  = share_count;
        push_cmd.price   = order_price;
        takes_ref        = 1'b0;
        if (operation == OP_RELEASE)
        begin
            push_cmd.kind    = KIND_RELEASE;
            push_cmd.ref_num = release_ref;
        end
        else
        begin
            unique case (order_side)
                SIDE_BUY:
                begin
                    push_cmd.kind    = KIND_ENTER;
                    push_cmd.ref_num = next_ref_reg;
                    push_cmd.sell    = 1'b0;
                    takes_ref        = 1'b1;
                end
                SIDE_SELL:
                begin
                    push_cmd.kind    = KIND_ENTER;
                    push_cmd.ref_num = next_ref_reg;
                    push_cmd.sell    = 1'b1;
                    takes_ref        = 1'b1;
                end
                default:
                begin
                    push_cmd.kind    = KIND_BAD;
                    push_cmd.ref_num = '0;
                end
            endcase
        end
    end

    // Reference counter: loaded by a configuration transfer, wraps at 32 bits.
    always_comb
    begin
        next_ref_next = next_ref_reg;
        if (cfg_valid && cfg_ready)
        begin
            next_ref_next = first_order_ref;
        end
        else if (in_xfer && takes_ref)
        begin
            next_ref_next = next_ref_reg + 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_ref_reg <= FIRST_REF_RESET;
        end
        else
        begin
            next_ref_reg <= next_ref_next;
        end
    end

endmodule

FILE: rtl/oeft_queue.sv
// Short command queue between the front and back parts.
// Depends on oeft_pkg for the command type and depth.
module oeft_queue
    import oeft_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cmd_t          push_cmd,
    input  logic          pop,
    output cmd_t          head,
    output queue_status_t q_stat
);

    cmd_t                q_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign q_stat.full  = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push & ~q_stat.full;
    assign do_pop       = pop & ~q_stat.empty;
    assign head         = q_mem[rd_ptr_reg];

    // Pointer and count updates; pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : wr_ptr_reg + QUEUE_AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0
                        : rd_ptr_reg + QUEUE_AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QUEUE_CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QUEUE_CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/oeft_back.sv
// Back part: pending table lookup and update, result and frame byte output.
// Depends on oeft_pkg and the assertion macro header.
`include "order_entry_framer_pending_table_assert.svh"

module oeft_back
    import oeft_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_t          q_head,
    input  queue_status_t q_stat,
    output logic          pop,
    output logic          clear_busy,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    frame_byte,
    output logic          last,
    output logic [2:0]    status,
    output logic [31:0]   order_ref
);

    localparam logic [1:0] BK_CLEAR = 2'd0;
    localparam logic [1:0] BK_IDLE  = 2'd1;
    localparam logic [1:0] BK_LOOK  = 2'd2;
    localparam logic [1:0] BK_EMIT  = 2'd3;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    slot_idx_t   clr_cnt_reg;
    slot_idx_t   clr_cnt_next;
    logic [LIVE_W-1:0] live_reg;
    logic [LIVE_W-1:0] live_next;
    byte_idx_t   byte_cnt_reg;
    byte_idx_t   byte_cnt_next;
    byte_idx_t   byte_inc;
    logic        out_valid_reg;
    logic        out_valid_next;
    cmd_t        cmd_reg;
    cmd_t        cmd_next;
    logic [7:0]  frame_byte_reg;
    logic [7:0]  frame_byte_next;
    logic        last_reg;
    logic        last_next;
    status_t     status_reg;
    status_t     status_next;
    logic [31:0] order_ref_reg;
    logic [31:0] order_ref_next;
    logic        out_xfer;

    // Pending table memory and its ports.
    slot_entry_t slot_mem [PENDING_SLOTS];
    slot_entry_t rd_data_reg;
    slot_idx_t   rd_addr;
    logic        wr_en;
    slot_idx_t   wr_addr;
    slot_entry_t wr_data;

    // Byte k of the enter-order frame, big-endian fields.
    function automatic logic [7:0] frame_byte_at(input byte_idx_t k, input cmd_t c);
        logic [7:0] b;
        case (k)
            5'd0:    b = FRAME_LEN[15:8];
            5'd1:    b = FRAME_LEN[7:0];
            5'd2:    b = CHAR_U;
            5'd3:    b = CHAR_O;
            5'd4:    b = c.ref_num[31:24];
            5'd5:    b = c.ref_num[23:16];
            5'd6:    b = c.ref_num[15:8];
            5'd7:    b = c.ref_num[7:0];
            5'd8:    b = c.sell ? CHAR_S : CHAR_B;
            5'd9:    b = c.locate[15:8];
            5'd10:   b = c.locate[7:0];
            5'd11:   b = c.shares[31:24];
            5'd12:   b = c.shares[23:16];
            5'd13:   b = c.shares[15:8];
            5'd14:   b = c.shares[7:0];
            5'd15:   b = c.price[31:24];
            5'd16:   b = c.price[23:16];
            5'd17:   b = c.price[15:8];
            5'd18:   b = c.price[7:0];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    assign clear_busy = (state_reg == BK_CLEAR);
    assign out_xfer   = out_valid_reg & ~out_stall;
    assign byte_inc   = byte_cnt_reg + BYTE_CW'(1);

    assign out_valid  = out_valid_reg;
    assign frame_byte = frame_byte_reg;
    assign last       = last_reg;
    assign status     = status_reg;
    assign order_ref  = order_ref_reg;

    // Sequencer: clear the table, take commands, look up, emit results.
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        live_next       = live_reg;
        byte_cnt_next   = byte_cnt_reg;
        out_valid_next  = out_valid_reg;
        cmd_next        = cmd_reg;
        frame_byte_next = frame_byte_reg;
        last_next       = last_reg;
        status_next     = status_reg;
        order_ref_next  = order_ref_reg;
        pop             = 1'b0;
        rd_addr         = slot_index(q_head.ref_num);
        wr_en           = 1'b0;
        wr_addr         = slot_index(cmd_reg.ref_num);
        wr_data         = '0;

        unique case (state_reg)
            BK_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + SLOT_AW'(1);
                if (clr_cnt_reg == SLOT_AW'(PENDING_SLOTS - 1))
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop        = 1'b1;
                    cmd_next   = q_head;
                    state_next = BK_LOOK;
                end
            end
            BK_LOOK:
            begin
                // Table entry for this command is in the read register now.
                byte_cnt_next   = '0;
                out_valid_next  = 1'b1;
                order_ref_next  = cmd_reg.ref_num;
                frame_byte_next = 8'h00;
                last_next       = 1'b1;
                state_next      = BK_EMIT;
                unique case (cmd_reg.kind)
                    KIND_BAD:
                    begin
                        status_next = STAT_BAD_SIDE;
                    end
                    KIND_RELEASE:
                    begin
                        if (rd_data_reg.occupied && rd_data_reg.ref_num == cmd_reg.ref_num)
                        begin
                            wr_en       = 1'b1;
                            status_next = STAT_RELEASED;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - LIVE_W'(1);
                            end
                        end
                        else
                        begin
                            status_next = STAT_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        if (live_reg == LIVE_W'(PENDING_SLOTS))
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (rd_data_reg.occupied)
                        begin
                            status_next = STAT_BUSY;
                        end
                        else
                        begin
                            wr_en            = 1'b1;
                            wr_data.occupied = 1'b1;
                            wr_data.ref_num  = cmd_reg.ref_num;
                            live_next        = live_reg + LIVE_W'(1);
                            status_next      = STAT_FRAME;
                            frame_byte_next  = frame_byte_at('0, cmd_reg);
                            last_next        = 1'b0;
                        end
                    end
                endcase
            end
            BK_EMIT:
            begin
                if (out_xfer)
                begin
                    if (last_reg)
                    begin
                        // Final transfer; start the next command at once if one waits.
                        out_valid_next = 1'b0;
                        if (!q_stat.empty)
                        begin
                            pop        = 1'b1;
                            cmd_next   = q_head;
                            state_next = BK_LOOK;
                        end
                        else
                        begin
                            state_next = BK_IDLE;
                        end
                    end
                    else
                    begin
                        byte_cnt_next   = byte_inc;
                        frame_byte_next = frame_byte_at(byte_inc, cmd_reg);
                        last_next       = (byte_inc == BYTE_CW'(FRAME_BYTES - 1));
                    end
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            live_reg      <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            live_reg      <= live_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        frame_byte_reg <= frame_byte_next;
        last_reg       <= last_next;
        status_reg     <= status_next;
        order_ref_reg  <= order_ref_next;
    end

    // Pending table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_addr];
    end

    // Checks on the sequencer and output register.
    `OEFT_ASSERT_NOW(a_no_out_in_clear, clk, rst_n, state_reg == BK_CLEAR, !out_valid_reg, "result offered during table clear")
    `OEFT_ASSERT_NOW(a_single_is_last, clk, rst_n, out_valid_reg && status_reg != STAT_FRAME, last_reg, "single result without last")
    `OEFT_ASSERT_NOW(a_frame_end_last, clk, rst_n, out_valid_reg && status_reg == STAT_FRAME && byte_cnt_reg == BYTE_CW'(FRAME_BYTES - 1), last_reg, "frame end without last")
    `OEFT_ASSERT_NOW(a_live_bound, clk, rst_n, 1'b1, live_reg <= LIVE_W'(PENDING_SLOTS), "live entry count above table size")
    `OEFT_ASSERT_NEXT(a_frame_continues, clk, rst_n, out_xfer && !last_reg, out_valid_reg, "frame broken off before last")

endmodule
